// ===== rtl/mept_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor encoder position tracker package
// Shared types, codes and constants for the tracker core, its divider and
// its port checker.
// ----------------------------------------------------------------------------
package mept_pkg;

   // Default width of the head encoder counter
   localparam int COUNT_BITS_DEF = 16;

   // Width of the register fields and of the reported fields
   localparam int FIELD_BITS = 16;

   // Remaining steps at or below this value request slow drive
   localparam int SLOW_THRESHOLD = 3;

   // Action codes of an input beat
   localparam logic [2:0] ACT_HEAD_A     = 3'd0;
   localparam logic [2:0] ACT_HEAD_B     = 3'd1;
   localparam logic [2:0] ACT_PULSE_LEFT = 3'd2;
   localparam logic [2:0] ACT_PULSE_RIGHT = 3'd3;
   localparam logic [2:0] ACT_LOAD_LEFT  = 3'd4;
   localparam logic [2:0] ACT_LOAD_RIGHT = 3'd5;

   // Wing direction codes
   localparam logic [1:0] WDIR_UP   = 2'd1;
   localparam logic [1:0] WDIR_DOWN = 2'd2;

   // Head zone codes
   localparam logic [1:0] ZONE_MIDDLE = 2'd0;
   localparam logic [1:0] ZONE_LEFT   = 2'd1;
   localparam logic [1:0] ZONE_RIGHT  = 2'd2;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_NORMAL_MODE = 3'd0;
   localparam logic [2:0] CSR_HEAD_UPPER  = 3'd1;
   localparam logic [2:0] CSR_HEAD_LOWER  = 3'd2;
   localparam logic [2:0] CSR_HEAD_CPD    = 3'd3;
   localparam logic [2:0] CSR_LEFT_CPD    = 3'd4;
   localparam logic [2:0] CSR_RIGHT_CPD   = 3'd5;

   // Input beat
   typedef struct packed {
      logic [2:0]  action;
      logic        level_a;
      logic        level_b;
      logic [1:0]  wing_direction;
      logic        wing_calibrated;
      logic [15:0] target_steps;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [15:0] head_count;
      logic        head_direction;
      logic [1:0]  head_zone;
      logic [15:0] head_angle;
      logic [15:0] wing_remaining;
      logic [15:0] wing_position;
      logic [15:0] wing_angle;
      logic        slow_down;
      logic        hold;
   } rsp_type;

   // Divider control and status
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // Sequencer states of the core
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

endpackage

// ===== rtl/mept_divider.sv =====
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Shifts the dividend in one bit per cycle and produces one quotient bit per
// cycle; the quotient is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module mept_divider #(
   parameter int DIVIDEND_BITS = mept_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mept_pkg::div_ctl_type               ctl,
   input  logic [DIVIDEND_BITS-1:0]            dividend,
   input  logic [mept_pkg::FIELD_BITS-1:0]     divisor,
   output mept_pkg::div_sts_type               sts,
   output logic [DIVIDEND_BITS-1:0]            quotient
);

   localparam int STEP_BITS = $clog2(DIVIDEND_BITS);
   localparam int FB        = mept_pkg::FIELD_BITS;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [FB-1:0]            rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [FB-1:0]            dvs_ff, dvs_in;

   logic [FB:0] shifted;
   logic [FB:0] diff;
   logic        fits;

   // Trial subtract of one digit
   assign shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   // Advance one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(DIVIDEND_BITS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[FB-1:0] : shifted[FB-1:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/motor_encoder_position_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Motor encoder position tracker core
// Head quadrature counter with zone and angle, plus step targets and
// position sums for the left and right wing motors.
// ----------------------------------------------------------------------------
// One input beat is worked on at a time and gives exactly one result beat.
// A beat that updates an angle (a head edge in normal mode, or a wing pulse,
// with a nonzero per-degree divisor) runs the shared bit-serial divider,
// one quotient bit per cycle over max(COUNT_BITS, 16) bits, before its result
// is loaded; the next beat is taken in the cycle that the result appears.
// Any other beat goes from the idle state straight to the output state, which
// loads the result only once the previous one is no longer stalled. The
// result sits in an output register, so a new input beat is taken while
// the previous result is still stalled. Configuration writes are always
// ready and belong in idle periods only.
module motor_encoder_position_tracker_core #(
   parameter int COUNT_BITS = mept_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mept_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mept_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam int WIDE_BITS = (COUNT_BITS > mept_pkg::FIELD_BITS) ?
                              COUNT_BITS : mept_pkg::FIELD_BITS;
   localparam int FB        = mept_pkg::FIELD_BITS;

   // Configuration registers
   logic          normal_mode_ff;
   logic [FB-1:0] head_upper_ff;
   logic [FB-1:0] head_lower_ff;
   logic [FB-1:0] head_cpd_ff;
   logic [FB-1:0] wing_cpd_ff [2];

   // Tracker state
   mept_pkg::state_type   state_ff, state_in;
   logic [COUNT_BITS-1:0] head_count_ff, head_count_in;
   logic                  head_dir_ff, head_dir_in;
   logic [1:0]            head_zone_ff, head_zone_in;
   logic [FB-1:0]         head_angle_ff, head_angle_in;
   logic [FB-1:0]         wing_rem_ff [2];
   logic [FB-1:0]         wing_pos_ff [2];
   logic [FB-1:0]         wing_ang_ff [2];
   logic [FB-1:0]         wing_rem_in, wing_pos_in, wing_ang_in;
   logic                  wing_rem_we, wing_pos_we, wing_ang_we;
   logic                  wing_sel_ff, wing_sel_in;
   logic                  wing_valid_ff, wing_valid_in;
   logic                  slow_ff, slow_in;
   logic                  hold_ff, hold_in;
   logic                  div_head_ff, div_head_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mept_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // Divider hookup
   mept_pkg::div_ctl_type div_ctl;
   mept_pkg::div_sts_type div_sts;
   logic [WIDE_BITS-1:0]  div_dividend;
   logic [FB-1:0]         div_divisor;
   logic [WIDE_BITS-1:0]  div_quotient;

   // Datapath helpers
   logic                  req_fire;
   logic                  out_free;
   logic                  w_idx;
   logic                  head_up;
   logic [COUNT_BITS-1:0] count_next;
   logic [WIDE_BITS-1:0]  count_wide;
   logic [WIDE_BITS-1:0]  count_now_wide;
   logic [FB-1:0]         rem_cur;
   logic [FB-1:0]         pos_cur;
   logic [FB-1:0]         pos_next;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != mept_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign w_idx     = req_data.action[0];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_mode_ff <= 1'b1;
         head_upper_ff  <= '0;
         head_lower_ff  <= '0;
         head_cpd_ff    <= '0;
         wing_cpd_ff[0] <= '0;
         wing_cpd_ff[1] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mept_pkg::CSR_NORMAL_MODE: normal_mode_ff <= csr_data[0];
            mept_pkg::CSR_HEAD_UPPER:  head_upper_ff  <= csr_data;
            mept_pkg::CSR_HEAD_LOWER:  head_lower_ff  <= csr_data;
            mept_pkg::CSR_HEAD_CPD:    head_cpd_ff    <= csr_data;
            mept_pkg::CSR_LEFT_CPD:    wing_cpd_ff[0] <= csr_data;
            mept_pkg::CSR_RIGHT_CPD:   wing_cpd_ff[1] <= csr_data;
            default: ;
         endcase
      end
   end

   // Head step: direction from the encoder levels, clamp at both ends
   always_comb begin
      if (req_data.action == mept_pkg::ACT_HEAD_B) begin
         head_up = (req_data.level_a != req_data.level_b);
      end else begin
         head_up = (req_data.level_a == req_data.level_b);
      end
      count_next = head_count_ff;
      if (head_up) begin
         if (head_count_ff != '1) count_next = head_count_ff + 1'b1;
      end else begin
         if (head_count_ff != '0) count_next = head_count_ff - 1'b1;
      end
      count_wide     = WIDE_BITS'(count_next);
      count_now_wide = WIDE_BITS'(head_count_ff);
   end

   // Wing step: position moves by the commanded direction, clamp at both ends
   always_comb begin
      rem_cur  = wing_rem_ff[w_idx];
      pos_cur  = wing_pos_ff[w_idx];
      pos_next = pos_cur;
      if (req_data.wing_direction == mept_pkg::WDIR_UP) begin
         if (pos_cur != '1) pos_next = pos_cur + 1'b1;
      end else if (req_data.wing_direction == mept_pkg::WDIR_DOWN) begin
         if (pos_cur != '0) pos_next = pos_cur - 1'b1;
      end
   end

   // Sequencer: take a beat, run the divider when an angle updates, load result
   always_comb begin
      state_in      = state_ff;
      head_count_in = head_count_ff;
      head_dir_in   = head_dir_ff;
      head_zone_in  = head_zone_ff;
      head_angle_in = head_angle_ff;
      wing_sel_in   = wing_sel_ff;
      wing_valid_in = wing_valid_ff;
      slow_in       = slow_ff;
      hold_in       = hold_ff;
      div_head_in   = div_head_ff;
      wing_rem_in   = wing_rem_ff[wing_sel_ff];
      wing_pos_in   = pos_next;
      wing_ang_in   = div_quotient[FB-1:0];
      wing_rem_we   = 1'b0;
      wing_pos_we   = 1'b0;
      wing_ang_we   = 1'b0;
      div_ctl.start = 1'b0;
      div_dividend  = WIDE_BITS'(pos_next);
      div_divisor   = wing_cpd_ff[w_idx];
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         mept_pkg::ST_IDLE: begin
            if (req_fire) begin
               wing_sel_in   = w_idx;
               wing_valid_in = 1'b0;
               slow_in       = 1'b0;
               hold_in       = 1'b0;
               state_in      = mept_pkg::ST_OUT;
               unique case (req_data.action) inside
                  mept_pkg::ACT_HEAD_A, mept_pkg::ACT_HEAD_B: begin
                     head_count_in = count_next;
                     head_dir_in   = head_up;
                     if (count_wide > WIDE_BITS'(head_upper_ff)) begin
                        head_zone_in = mept_pkg::ZONE_RIGHT;
                     end else if (count_wide < WIDE_BITS'(head_lower_ff)) begin
                        head_zone_in = mept_pkg::ZONE_LEFT;
                     end else begin
                        head_zone_in = mept_pkg::ZONE_MIDDLE;
                     end
                     div_dividend = count_wide;
                     div_divisor  = head_cpd_ff;
                     div_head_in  = 1'b1;
                     if (normal_mode_ff && (head_cpd_ff != '0)) begin
                        div_ctl.start = 1'b1;
                        state_in      = mept_pkg::ST_DIV;
                     end
                  end
                  mept_pkg::ACT_PULSE_LEFT, mept_pkg::ACT_PULSE_RIGHT: begin
                     wing_valid_in = 1'b1;
                     wing_pos_we   = 1'b1;
                     wing_rem_we   = 1'b1;
                     slow_in       = (rem_cur <= FB'(mept_pkg::SLOW_THRESHOLD)) &&
                                     req_data.wing_calibrated;
                     hold_in       = (rem_cur <= FB'(1));
                     wing_rem_in   = (rem_cur <= FB'(1)) ? '0 : rem_cur - 1'b1;
                     div_head_in   = 1'b0;
                     if (wing_cpd_ff[w_idx] != '0) begin
                        div_ctl.start = 1'b1;
                        state_in      = mept_pkg::ST_DIV;
                     end
                  end
                  mept_pkg::ACT_LOAD_LEFT, mept_pkg::ACT_LOAD_RIGHT: begin
                     wing_valid_in = 1'b1;
                     wing_rem_we   = 1'b1;
                     wing_rem_in   = req_data.target_steps;
                  end
                  default: ;
               endcase
            end
         end
         mept_pkg::ST_DIV: begin
            if (div_sts.done) begin
               if (div_head_ff) begin
                  head_angle_in = (div_quotient > WIDE_BITS'({FB{1'b1}})) ?
                                  '1 : div_quotient[FB-1:0];
               end else begin
                  wing_ang_we = 1'b1;
               end
               state_in = mept_pkg::ST_OUT;
            end
         end
         mept_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.head_count     = count_now_wide[FB-1:0];
               rsp_data_in.head_direction = head_dir_ff;
               rsp_data_in.head_zone      = head_zone_ff;
               rsp_data_in.head_angle     = head_angle_ff;
               rsp_data_in.wing_remaining = wing_valid_ff ? wing_rem_ff[wing_sel_ff] : '0;
               rsp_data_in.wing_position  = wing_valid_ff ? wing_pos_ff[wing_sel_ff] : '0;
               rsp_data_in.wing_angle     = wing_valid_ff ? wing_ang_ff[wing_sel_ff] : '0;
               rsp_data_in.slow_down      = slow_ff;
               rsp_data_in.hold           = hold_ff;
               state_in                   = mept_pkg::ST_IDLE;
            end
         end
         default: state_in = mept_pkg::ST_IDLE;
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mept_pkg::ST_IDLE;
         head_count_ff <= '0;
         head_dir_ff   <= 1'b0;
         head_zone_ff  <= mept_pkg::ZONE_MIDDLE;
         head_angle_ff <= '0;
         wing_rem_ff[0] <= '0;
         wing_rem_ff[1] <= '0;
         wing_pos_ff[0] <= '0;
         wing_pos_ff[1] <= '0;
         wing_ang_ff[0] <= '0;
         wing_ang_ff[1] <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_count_ff <= head_count_in;
         head_dir_ff   <= head_dir_in;
         head_zone_ff  <= head_zone_in;
         head_angle_ff <= head_angle_in;
         if (wing_rem_we) wing_rem_ff[wing_sel_in] <= wing_rem_in;
         if (wing_pos_we) wing_pos_ff[wing_sel_in] <= wing_pos_in;
         if (wing_ang_we) wing_ang_ff[wing_sel_ff] <= wing_ang_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      wing_sel_ff   <= wing_sel_in;
      wing_valid_ff <= wing_valid_in;
      slow_ff       <= slow_in;
      hold_ff       <= hold_in;
      div_head_ff   <= div_head_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Shared angle divider
   mept_divider #(
      .DIVIDEND_BITS (WIDE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/mept_checker.sv =====
// ----------------------------------------------------------------------------
// Motor encoder position tracker port checker
// Watches the request and result ports of the core over time.
// ----------------------------------------------------------------------------
module mept_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mept_pkg::rsp_type rsp_data
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // One beat in flight: a taken beat stalls the next one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a beat is in flight");

   // Hold means the wing target is used up
   a_hold_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hold |-> rsp_data.wing_remaining == 16'd0)
      else $error("hold with steps remaining");

   // Slow drive only near the target
   a_slow_near: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.slow_down |-> rsp_data.wing_remaining < 16'd3)
      else $error("slow drive far from target");

   // Drop results on reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind motor_encoder_position_tracker_core mept_checker u_checker (.*);
